// ----- src/teg_pkg.sv -----
`default_nettype none
package teg_pkg;

  // field widths
  localparam int unsigned AMP_W    = 8;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned THR_W    = 12;
  localparam int unsigned LIMIT_W  = 13;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned HALF_W   = 11;
  localparam int unsigned PROD_W   = DUR_W + LEVEL_W;
  localparam int unsigned DIV_STEPS = LEVEL_W;
  localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS + 1);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIME        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_TIME        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_LIMIT     = 3'd4;

  // register reset values
  localparam logic [DUR_W-1:0]   RISE_TIME_RST   = 16'd400;
  localparam logic [DUR_W-1:0]   HOLD_TIME_RST   = 16'd200;
  localparam logic [DUR_W-1:0]   FALL_TIME_RST   = 16'd800;
  localparam logic [THR_W-1:0]   SPREAD_THR_RST  = 12'd2048;
  localparam logic [LIMIT_W-1:0] ACCEPT_LIM_RST  = 13'd1638;

  // input commands
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_TRIGGER = 1'b1;

  // envelope phases
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_RISE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HOLD = 2'd2;
  localparam logic [PHASE_W-1:0] PH_FALL = 2'd3;

  // 1/17 as 241/4096, exact for every 8-bit amplitude
  localparam logic [AMP_W-1:0] RECIP17 = 8'd241;

  typedef struct packed {
    logic accept;
    logic mul;
    logic step;
    logic finish;
    logic load_out;
  } teg_cmd_t;

  typedef struct packed {
    logic need_div;
  } teg_sts_t;

  // amplitude*4095/255 == 16*amplitude + amplitude/17
  function automatic logic [LEVEL_W-1:0] scale_amp(input logic [AMP_W-1:0] amp);
    logic [15:0] prod;
    prod = 16'(amp) * 16'(RECIP17);
    return {amp, 4'b0000} + LEVEL_W'(prod[15:12]);
  endfunction

endpackage
`default_nettype wire

// ----- src/teg_if.sv -----
`default_nettype none
interface teg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [teg_pkg::AMP_W-1:0]     amplitude;

  modport source (output valid, output command, output amplitude, input ready);
  modport sink (input valid, input command, input amplitude, output ready);
endinterface

interface teg_out_if;
  logic                          valid;
  logic                          ready;
  logic [teg_pkg::LEVEL_W-1:0]   pwm_level;
  logic [teg_pkg::PHASE_W-1:0]   phase;
  logic                          spread_request;
  logic [teg_pkg::HALF_W-1:0]    spread_amplitude;
  logic                          accepts_wave;

  modport source (output valid, output pwm_level, output phase, output spread_request,
                  output spread_amplitude, output accepts_wave, input ready);
  modport sink (input valid, input pwm_level, input phase, input spread_request,
                input spread_amplitude, input accepts_wave, output ready);
endinterface
`default_nettype wire

// ----- src/teg_ctrl.sv -----
`default_nettype none
module teg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              out_ready,
  output logic                   out_valid,
  input  wire teg_pkg::teg_sts_t sts,
  output teg_pkg::teg_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]                       state_r, state_nxt;
  logic [teg_pkg::STEP_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.need_div ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == teg_pkg::STEP_CNT_W'(teg_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/teg_datapath.sv -----
`default_nettype none
module teg_datapath #(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [teg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [teg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             in_command,
  input  wire logic [teg_pkg::AMP_W-1:0]        in_amplitude,
  input  wire teg_pkg::teg_cmd_t                cmd,
  output teg_pkg::teg_sts_t                     sts,
  output logic [teg_pkg::LEVEL_W-1:0]           out_pwm_level,
  output logic [teg_pkg::PHASE_W-1:0]           out_phase,
  output logic                                  out_spread_request,
  output logic [teg_pkg::HALF_W-1:0]            out_spread_amplitude,
  output logic                                  out_accepts_wave
);

  localparam int unsigned DW = teg_pkg::DUR_W;
  localparam int unsigned LW = teg_pkg::LEVEL_W;
  // compare width: holds elapsed time and rise+hold without overflow
  localparam int unsigned CW = ((TIME_BITS > DW + 1) ? TIME_BITS : DW + 1) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // configuration registers
  logic [DW-1:0]                 rise_time_r, hold_time_r, fall_time_r;
  logic [teg_pkg::THR_W-1:0]     spread_thr_r;
  logic [teg_pkg::LIMIT_W-1:0]   accept_lim_r;

  // envelope state
  logic [teg_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [TIME_BITS-1:0]          elapsed_r, elapsed_nxt;
  logic [LW-1:0]                 peak_r, peak_nxt;
  logic [LW-1:0]                 drive_r, drive_nxt;

  // divider operands and working registers
  logic [DW-1:0]                 x_r, x_nxt;
  logic [DW-1:0]                 d_r, d_nxt;
  logic                          fall_r, fall_nxt;
  logic [DW-1:0]                 rem_r;
  logic [LW-1:0]                 low_r;
  logic [LW-1:0]                 quo_r;

  logic [TIME_BITS-1:0]          t_inc;
  logic [CW-1:0]                 t_c, rise_c, rh_c, f_c;
  logic [teg_pkg::PROD_W-1:0]    prod;
  logic [DW:0]                   rem_sh, rem_diff;
  logic                          q_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_time_r  <= teg_pkg::RISE_TIME_RST;
      hold_time_r  <= teg_pkg::HOLD_TIME_RST;
      fall_time_r  <= teg_pkg::FALL_TIME_RST;
      spread_thr_r <= teg_pkg::SPREAD_THR_RST;
      accept_lim_r <= teg_pkg::ACCEPT_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        teg_pkg::CFG_RISE_TIME:        rise_time_r  <= cfg_wdata;
        teg_pkg::CFG_HOLD_TIME:        hold_time_r  <= cfg_wdata;
        teg_pkg::CFG_FALL_TIME:        fall_time_r  <= cfg_wdata;
        teg_pkg::CFG_SPREAD_THRESHOLD: spread_thr_r <= cfg_wdata[teg_pkg::THR_W-1:0];
        teg_pkg::CFG_ACCEPT_LIMIT:     accept_lim_r <= cfg_wdata[teg_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // saturating millisecond count and phase bounds
  assign t_inc  = (elapsed_r == TIME_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign t_c    = CW'(t_inc);
  assign rise_c = CW'(rise_time_r);
  assign rh_c   = CW'(rise_time_r) + CW'(hold_time_r);
  assign f_c    = (t_c > rh_c) ? (t_c - rh_c) : '0;

  // request decode: everything but the ramp quotient settles here
  always_comb begin
    phase_nxt    = phase_r;
    elapsed_nxt  = elapsed_r;
    peak_nxt     = peak_r;
    drive_nxt    = drive_r;
    x_nxt        = x_r;
    d_nxt        = d_r;
    fall_nxt     = fall_r;
    sts.need_div = 1'b0;
    if (in_command == teg_pkg::CMD_TRIGGER) begin
      peak_nxt    = teg_pkg::scale_amp(in_amplitude);
      elapsed_nxt = '0;
      phase_nxt   = teg_pkg::PH_RISE;
    end else begin
      elapsed_nxt = t_inc;
      case (phase_r)
        teg_pkg::PH_RISE: begin
          if (rise_c > t_c) begin
            sts.need_div = 1'b1;
            x_nxt        = t_c[DW-1:0];
            d_nxt        = rise_time_r;
            fall_nxt     = 1'b0;
          end else begin
            drive_nxt = peak_r;
            phase_nxt = teg_pkg::PH_HOLD;
          end
        end
        teg_pkg::PH_HOLD: begin
          if (rh_c > t_c) begin
            drive_nxt = peak_r;
          end else begin
            phase_nxt = teg_pkg::PH_FALL;
          end
        end
        teg_pkg::PH_FALL: begin
          if (f_c < CW'(fall_time_r)) begin
            sts.need_div = 1'b1;
            x_nxt        = f_c[DW-1:0];
            d_nxt        = fall_time_r;
            fall_nxt     = 1'b1;
          end else begin
            drive_nxt = '0;
            phase_nxt = teg_pkg::PH_IDLE;
          end
        end
        default: begin
          peak_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= teg_pkg::PH_IDLE;
      elapsed_r <= '0;
      peak_r    <= '0;
      drive_r   <= '0;
    end else if (cmd.accept) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      peak_r    <= peak_nxt;
      drive_r   <= drive_nxt;
    end else if (cmd.finish) begin
      drive_r <= fall_r ? (peak_r - quo_r) : quo_r;
    end
  end

  // ramp product, then restoring division one quotient bit a cycle
  assign prod     = teg_pkg::PROD_W'(x_r) * teg_pkg::PROD_W'(peak_r);
  assign rem_sh   = {rem_r, low_r[LW-1]};
  assign q_bit    = (rem_sh >= {1'b0, d_r});
  assign rem_diff = rem_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r    <= x_nxt;
      d_r    <= d_nxt;
      fall_r <= fall_nxt;
    end
    if (cmd.mul) begin
      rem_r <= prod[teg_pkg::PROD_W-1:LW];
      low_r <= prod[LW-1:0];
      quo_r <= '0;
    end else if (cmd.step) begin
      rem_r <= q_bit ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
      low_r <= {low_r[LW-2:0], 1'b0};
      quo_r <= {quo_r[LW-2:0], q_bit};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pwm_level        <= drive_r;
      out_phase            <= phase_r;
      out_spread_request   <= (peak_r > spread_thr_r);
      out_spread_amplitude <= peak_r[LW-1:1];
      out_accepts_wave     <= (teg_pkg::LIMIT_W'(peak_r) <= accept_lim_r);
    end
  end

endmodule
`default_nettype wire

// ----- src/trapezoid_envelope_generator_top.sv -----
`default_nettype none
// Trapezoid (rise / hold / fall) drive-level envelope for a vibration motor.
// in_ch carries requests: command 1 triggers a wave with the given 8-bit
// amplitude, command 0 is a one millisecond tick. Every request yields
// exactly one result on out_ch: level, phase, spread request and amplitude,
// and the accept flag. Durations and thresholds come from the cfg_ port; the
// user must write them while the block is idle; the block does not check.
// A trigger, or a tick that needs no ramp value, goes from accept straight
// to the result load. A tick on a rise or fall ramp passes the 16x12 product,
// 12 steps of the shared restoring divider (one quotient bit a cycle), the
// level write and the result load.
// One request is in work at a time; in_ch.ready is high when the sequencer
// is idle, so the next request may enter while a result waits in the output
// register. When out_ch stalls, the result holds and the following request
// waits in its final cycle until the register frees.
// Reset (rst_n low, synchronous) restores the register defaults, puts the
// envelope in idle with zero level, peak and elapsed time, and drops
// out_ch.valid.
module trapezoid_envelope_generator_top #(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  teg_in_if.sink                               in_ch,
  teg_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [teg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [teg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  teg_pkg::teg_cmd_t cmd;
  teg_pkg::teg_sts_t sts;

  // sequencer
  teg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // envelope state, divider and result register
  teg_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_command           (in_ch.command),
    .in_amplitude         (in_ch.amplitude),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_pwm_level        (out_ch.pwm_level),
    .out_phase            (out_ch.phase),
    .out_spread_request   (out_ch.spread_request),
    .out_spread_amplitude (out_ch.spread_amplitude),
    .out_accepts_wave     (out_ch.accepts_wave)
  );

endmodule
`default_nettype wire

// ----- src/teg_checker.sv -----
`default_nettype none
module teg_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [teg_pkg::LEVEL_W-1:0]   pwm_level,
  input  wire logic [teg_pkg::PHASE_W-1:0]   phase,
  input  wire logic [teg_pkg::HALF_W-1:0]    spread_amplitude
);

  // a pending result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in work");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // idle phase always drives zero
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && phase == teg_pkg::PH_IDLE |-> pwm_level == '0)
    else $error("nonzero level in idle phase");

  // hold phase drives the peak, compared without its lowest bit
  a_hold_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && phase == teg_pkg::PH_HOLD |-> pwm_level[teg_pkg::LEVEL_W-1:1] == spread_amplitude)
    else $error("hold level differs from peak");

endmodule

bind trapezoid_envelope_generator_top teg_checker u_teg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .pwm_level        (out_ch.pwm_level),
  .phase            (out_ch.phase),
  .spread_amplitude (out_ch.spread_amplitude)
);
`default_nettype wire
